@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the ticket queue core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock outside reset
`define CSQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication into the following cycle
`define CSQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/core/csq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csq_pkg
// constants, codes and control types of the class selective ticket queue
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int TICKET_BITS    = 16;
    localparam int COUNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_BITS       = $clog2(QUEUE_DEPTH);
    localparam int CLASS_BITS     = 2;
    localparam int SERVER_BITS    = 3;
    localparam int SERVER_COUNT   = 4;
    localparam int CFG_INDEX_BITS = $clog2(SERVER_COUNT);

    typedef logic [CLASS_BITS-1:0] class_t;

    localparam class_t CLASS_PRIORITY = 2'd0;
    localparam class_t CLASS_COMMON   = 2'd1;
    localparam class_t CLASS_QUICK    = 2'd2;
    localparam class_t CLASS_INVALID  = 2'd3;

    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_SERVE   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_EMPTY   = 2'd2,
        STATUS_INVALID = 2'd3
    } status_t;

    localparam class_t SERVER_CLASS_RESET [SERVER_COUNT] =
        '{CLASS_PRIORITY, CLASS_COMMON, CLASS_COMMON, CLASS_QUICK};

    typedef struct packed {
        logic capture;
        logic execute;
    } csq_cmd_t;

    typedef struct packed {
        logic out_free;
    } csq_stat_t;

endpackage

@@ rtl/core/csq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csq_ctrl
// controller: takes one request beat, runs it on a free output slot
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csq_ctrl import csq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  csq_stat_t stat,
    output csq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        STATE_IDLE = 2'b01,
        STATE_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            STATE_IDLE: begin
                if (s_valid) begin
                    state_next = STATE_EXEC;
                end
            end
            STATE_EXEC: begin
                if (stat.out_free) begin
                    state_next = STATE_IDLE;
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready     = (state_reg == STATE_IDLE);
    assign cmd.capture = s_valid && s_ready;
    assign cmd.execute = (state_reg == STATE_EXEC) && stat.out_free;

    `CSQ_ASSERT_NEXT(a_exec_waits, (state_reg == STATE_EXEC) && !stat.out_free, state_reg == STATE_EXEC, "request dropped while output slot busy")

endmodule

@@ rtl/core/csq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csq_datapath
// shifting ticket store, class match and pick, server map, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csq_datapath import csq_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  csq_cmd_t                  cmd,
    output csq_stat_t                 stat,
    input  logic                      s_kind,
    input  logic [CLASS_BITS-1:0]     s_ticket_class,
    input  logic [SERVER_BITS-1:0]    s_server_id,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CLASS_BITS-1:0]     cfg_wdata,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [TICKET_BITS-1:0]    m_ticket_number,
    output logic [CLASS_BITS-1:0]     m_served_class,
    output logic [COUNT_BITS-1:0]     m_fill_count
);

    // captured request
    logic                   kind_reg;
    class_t                 class_reg;
    logic [SERVER_BITS-1:0] server_reg;

    class_t                 srv_class_reg [SERVER_COUNT];

    // entry store, only the first count_reg entries are meaningful
    class_t                 entry_cls_reg [QUEUE_DEPTH];
    logic [TICKET_BITS-1:0] entry_tkt_reg [QUEUE_DEPTH];

    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [TICKET_BITS-1:0] ticket_reg;
    logic [TICKET_BITS-1:0] ticket_next;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    status_t                m_status_reg;
    logic [TICKET_BITS-1:0] m_ticket_reg;
    class_t                 m_class_reg;
    logic [COUNT_BITS-1:0]  m_count_reg;

    logic [CFG_INDEX_BITS-1:0] srv_idx;
    class_t                 want;
    logic [QUEUE_DEPTH-1:0] match;
    logic [IDX_BITS-1:0]    pick;
    logic                   is_full;
    logic                   is_empty;
    logic                   bad_server;
    logic                   do_enq;
    logic                   do_serve;
    status_t                res_status;
    logic [TICKET_BITS-1:0] res_ticket;
    class_t                 res_class;
    logic [COUNT_BITS-1:0]  res_count;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= s_kind;
            class_reg  <= s_ticket_class;
            server_reg <= s_server_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srv_class_reg <= SERVER_CLASS_RESET;
        end else if (cfg_wr_en) begin
            srv_class_reg[cfg_index] <= cfg_wdata;
        end
    end

    // oldest waiting entry of the wanted class, head when none
    assign srv_idx = CFG_INDEX_BITS'(server_reg - SERVER_BITS'(1));
    assign want    = srv_class_reg[srv_idx];

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            match[i] = (COUNT_BITS'(i) < count_reg) && (entry_cls_reg[i] == want);
        end
        pick = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                pick = IDX_BITS'(i);
            end
        end
    end

    assign is_full    = (count_reg == COUNT_BITS'(QUEUE_DEPTH));
    assign is_empty   = (count_reg == '0);
    assign bad_server = (server_reg == '0) || (server_reg > SERVER_BITS'(SERVER_COUNT));

    assign do_enq   = cmd.execute && (kind_reg == KIND_ENQUEUE) && !is_full
                      && (class_reg != CLASS_INVALID);
    assign do_serve = cmd.execute && (kind_reg == KIND_SERVE) && !is_empty && !bad_server;

    always_comb begin
        res_status = STATUS_OK;
        res_ticket = '0;
        res_class  = CLASS_PRIORITY;
        res_count  = count_reg;
        if (kind_reg == KIND_ENQUEUE) begin
            if (is_full) begin
                res_status = STATUS_FULL;
            end else if (class_reg == CLASS_INVALID) begin
                res_status = STATUS_INVALID;
            end else begin
                res_ticket = ticket_reg;
                res_class  = class_reg;
                res_count  = COUNT_BITS'(count_reg + 1'b1);
            end
        end else begin
            if (is_empty) begin
                res_status = STATUS_EMPTY;
            end else if (bad_server) begin
                res_status = STATUS_INVALID;
            end else begin
                res_ticket = entry_tkt_reg[pick];
                res_class  = entry_cls_reg[pick];
                res_count  = COUNT_BITS'(count_reg - 1'b1);
            end
        end
    end

    assign count_next  = cmd.execute ? res_count : count_reg;
    assign ticket_next = do_enq ? TICKET_BITS'(ticket_reg + 1'b1) : ticket_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            ticket_reg <= TICKET_BITS'(1);
        end else begin
            count_reg  <= count_next;
            ticket_reg <= ticket_next;
        end
    end

    // serve shifts slots from pick up; enqueue writes new ticket at tail
    always_ff @(posedge aclk) begin
        if (do_serve) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (IDX_BITS'(i) >= pick) begin
                    entry_cls_reg[i] <= entry_cls_reg[i+1];
                    entry_tkt_reg[i] <= entry_tkt_reg[i+1];
                end
            end
        end else if (do_enq) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (COUNT_BITS'(i) == count_reg) begin
                    entry_cls_reg[i] <= class_reg;
                    entry_tkt_reg[i] <= ticket_reg;
                end
            end
        end
    end

    // result beat register
    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid_next  = cmd.execute || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            m_status_reg <= res_status;
            m_ticket_reg <= res_ticket;
            m_class_reg  <= res_class;
            m_count_reg  <= res_count;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_ticket_number = m_ticket_reg;
    assign m_served_class  = m_class_reg;
    assign m_fill_count    = m_count_reg;

    `CSQ_ASSERT(a_count_bound, count_reg <= COUNT_BITS'(QUEUE_DEPTH), "fill count beyond queue depth")
    `CSQ_ASSERT(a_exec_slot_free, !cmd.execute || !m_valid_reg || m_ready, "result beat overwritten")
    `CSQ_ASSERT_NEXT(a_count_hold, !cmd.execute, $stable(count_reg), "fill count moved without a request")

endmodule

@@ rtl/core/class_select_shift_queue_core.sv @@
`timescale 1ns / 1ps
// a request beat is captured in idle, then run in the execute step, and its
// result beat is registered; s_ready stays low until the request has run
// a stalled result holds the execute step until the output register frees
// reset: aresetn synchronous, active low; clears fill count, ticket number to 1,
// server map to 0, 1, 1, 2; no clearing pass, the entry store is never swept
// ----------------------------------------------------------------------------
// class_select_shift_queue_core
// class selective shifting ticket queue with per server class map
// ----------------------------------------------------------------------------
module class_select_shift_queue_core import csq_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [CLASS_BITS-1:0]     s_ticket_class,
    input  logic [SERVER_BITS-1:0]    s_server_id,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [TICKET_BITS-1:0]    m_ticket_number,
    output logic [CLASS_BITS-1:0]     m_served_class,
    output logic [COUNT_BITS-1:0]     m_fill_count,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CLASS_BITS-1:0]     cfg_wdata
);

    csq_cmd_t  cmd;
    csq_stat_t stat;

    csq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    csq_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_kind          (s_kind),
        .s_ticket_class  (s_ticket_class),
        .s_server_id     (s_server_id),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_ticket_number (m_ticket_number),
        .m_served_class  (m_served_class),
        .m_fill_count    (m_fill_count)
    );

endmodule
